// ===== sv/assert_macros.svh =====
// Assertion macros shared by the four-pole filter RTL.
// Needs nothing else; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

// The expression must hold in every cycle outside reset.
`define FPR_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant check failed");

`endif

// ===== sv/fpr_pkg.sv =====
// Package for the four-pole resonant filter: widths, types, codes and
// saturation helpers. Depends on nothing; every file but assert_macros.svh uses it.
`default_nettype none

package fpr_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 16;
   localparam int FB_BITS     = 20;
   localparam int FB_FRAC     = 16;
   localparam int STAGE_BITS  = 32;
   localparam int DIFF_BITS   = STAGE_BITS + 1;
   localparam int MUL_A_BITS  = ((FB_BITS > COEF_BITS) ? FB_BITS : COEF_BITS) + 1;
   localparam int PROD_BITS   = MUL_A_BITS + DIFF_BITS;
   localparam int WIDE_BITS   = PROD_BITS + 1;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = FB_BITS;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic        [COEF_BITS-1:0]   coef_type;
   typedef logic        [FB_BITS-1:0]     fb_type;
   typedef logic signed [STAGE_BITS-1:0]  stage_type;
   typedef logic signed [DIFF_BITS-1:0]   diff_type;
   typedef logic signed [MUL_A_BITS-1:0]  mul_a_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [WIDE_BITS-1:0]   wide_type;
   typedef logic [CSR_ADDR_BITS-1:0]      csr_addr_type;
   typedef logic [CSR_DATA_BITS-1:0]      csr_data_type;

   // Configuration register indexes.
   localparam csr_addr_type CSR_FILTER_MODE   = csr_addr_type'(0);
   localparam csr_addr_type CSR_FEEDBACK_GAIN = csr_addr_type'(1);

   typedef enum logic [1:0] {
      MODE_LOWPASS,
      MODE_HIGHPASS,
      MODE_BANDPASS,
      MODE_ZERO
   } mode_type;

   // Sequencer states: one multiply, then one use of its product.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_FB,
      ST_ERR,
      ST_MUL_S1,
      ST_UPD_S1,
      ST_MUL_S2,
      ST_UPD_S2,
      ST_MUL_S3,
      ST_UPD_S3,
      ST_MUL_S4,
      ST_UPD_S4,
      ST_OUT
   } state_type;

   // Second multiplier operand.
   typedef enum logic [1:0] {
      BSEL_S1_S2,
      BSEL_ERR,
      BSEL_S2_S3,
      BSEL_S3_S4
   } bsel_type;

   typedef enum logic [1:0] {
      STG_ONE,
      STG_TWO,
      STG_THREE,
      STG_FOUR
   } stage_sel_type;

   // Sequencer to datapath.
   typedef struct packed {
      logic          ready;
      logic          mul_en;
      logic          a_is_fb;
      bsel_type      b_sel;
      logic          err_en;
      logic          upd_en;
      stage_sel_type upd_sel;
      logic          out_load;
   } ctl_type;

   // Datapath to sequencer.
   typedef struct packed {
      logic accept;
      logic zero_in;
      logic out_free;
   } sts_type;

   // Saturate a wide sum to the signed stage range.
   function automatic stage_type sat_stage(input wide_type v);
      logic all_ones;
      logic all_zeros;
      all_ones  = &v[WIDE_BITS-1:STAGE_BITS-1];
      all_zeros = ~|v[WIDE_BITS-1:STAGE_BITS-1];
      if (all_ones || all_zeros) begin
         sat_stage = v[STAGE_BITS-1:0];
      end else if (v[WIDE_BITS-1]) begin
         sat_stage = {1'b1, {(STAGE_BITS-1){1'b0}}};
      end else begin
         sat_stage = {1'b0, {(STAGE_BITS-1){1'b1}}};
      end
   endfunction

   // Saturate a stage difference to the signed sample range.
   function automatic sample_type sat_sample(input diff_type v);
      logic all_ones;
      logic all_zeros;
      all_ones  = &v[DIFF_BITS-1:SAMPLE_BITS-1];
      all_zeros = ~|v[DIFF_BITS-1:SAMPLE_BITS-1];
      if (all_ones || all_zeros) begin
         sat_sample = v[SAMPLE_BITS-1:0];
      end else if (v[DIFF_BITS-1]) begin
         sat_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/fpr_ifs.sv =====
// Channel interfaces of the four-pole resonant filter: sample request,
// filtered response and register write. Depends on fpr_pkg.
`default_nettype none

interface fpr_req_if;
   logic                 valid;
   logic                 ready;
   fpr_pkg::sample_type  sample_in;
   fpr_pkg::coef_type    cutoff_coef;

   modport source (output valid, output sample_in, output cutoff_coef, input ready);
   modport sink   (input valid, input sample_in, input cutoff_coef, output ready);
endinterface

interface fpr_rsp_if;
   logic                 valid;
   logic                 ready;
   fpr_pkg::sample_type  sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface fpr_csr_if;
   logic                  valid;
   logic                  ready;
   fpr_pkg::csr_addr_type addr;
   fpr_pkg::csr_data_type wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/four_pole_resonant_filter.sv =====
// Four-pole resonant filter: four cascaded one-pole stages, the first with
// resonance feedback, evaluated with one shared multiplier.
// Depends on fpr_pkg, fpr_ifs, fpr_mul, fpr_ctrl and assert_macros.svh.
//
// Channels: req_ch takes one word (sample_in, cutoff_coef); rsp_ch gives one
// word (sample_out) per request word, in order. csr_ch writes filter_mode
// (index 0) and feedback_gain (index 1); it is always ready and other
// indexes are dropped. The user must write it only while the filter is
// idle; the block does not enforce this. A nonzero sample runs five
// multiplies in turn through the one multiplier, each followed by a step
// that uses its product, then the output step; a zero sample leaves the
// stages alone and goes straight to the output step. The result shows on
// rsp_ch, and req_ch is ready again (never earlier), in the same cycle.
// The result sits in an output register, so req_ch takes the next word while
// it waits; a later result that finds the register still full holds in the
// last sequencer step until rsp_ch.ready frees it.
// Reset (synchronous, active high) clears the stages and both registers.
`default_nettype none
`include "assert_macros.svh"

module four_pole_resonant_filter (
   input  wire              clock,
   input  wire              reset,
   fpr_req_if.sink          req_ch,
   fpr_rsp_if.source        rsp_ch,
   fpr_csr_if.sink          csr_ch
);

   fpr_pkg::ctl_type    ctl;
   fpr_pkg::sts_type    sts;

   fpr_pkg::mode_type   mode_ff;
   fpr_pkg::fb_type     fb_ff;
   fpr_pkg::sample_type x_ff;
   fpr_pkg::coef_type   c_ff;
   fpr_pkg::stage_type  e_ff;
   fpr_pkg::stage_type  e_in;
   fpr_pkg::stage_type  s1_ff, s2_ff, s3_ff, s4_ff;
   fpr_pkg::stage_type  stage_cur;
   fpr_pkg::stage_type  stage_new;
   fpr_pkg::sample_type sample_out_ff;
   fpr_pkg::sample_type sample_out_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   fpr_pkg::mul_a_type  mul_a;
   fpr_pkg::diff_type   mul_b;
   fpr_pkg::prod_type   prod;
   fpr_pkg::diff_type   y_raw;
   logic                accept;

   assign accept        = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = ctl.ready;
   assign csr_ch.ready  = 1'b1;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sample_out = sample_out_ff;

   assign sts.accept   = accept;
   assign sts.zero_in  = (req_ch.sample_in == '0);
   assign sts.out_free = !rsp_valid_ff || rsp_ch.ready;

   fpr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = ctl.a_is_fb ? fpr_pkg::mul_a_type'(fb_ff) : fpr_pkg::mul_a_type'(c_ff);
      case (ctl.b_sel)
         fpr_pkg::BSEL_S1_S2: mul_b = fpr_pkg::diff_type'(s1_ff) - fpr_pkg::diff_type'(s2_ff);
         fpr_pkg::BSEL_ERR:   mul_b = fpr_pkg::diff_type'(e_ff);
         fpr_pkg::BSEL_S2_S3: mul_b = fpr_pkg::diff_type'(s2_ff) - fpr_pkg::diff_type'(s3_ff);
         fpr_pkg::BSEL_S3_S4: mul_b = fpr_pkg::diff_type'(s3_ff) - fpr_pkg::diff_type'(s4_ff);
         default:             mul_b = '0;
      endcase
   end

   fpr_mul u_mul (
      .clock (clock),
      .en    (ctl.mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // Error term: input minus stage one plus the floored feedback product.
   always_comb begin
      e_in = fpr_pkg::sat_stage(fpr_pkg::wide_type'(x_ff) - fpr_pkg::wide_type'(s1_ff)
                                + fpr_pkg::wide_type'(prod >>> fpr_pkg::FB_FRAC));
   end

   // Stage update: stage plus the floored coefficient product, saturated.
   always_comb begin
      case (ctl.upd_sel)
         fpr_pkg::STG_ONE:   stage_cur = s1_ff;
         fpr_pkg::STG_TWO:   stage_cur = s2_ff;
         fpr_pkg::STG_THREE: stage_cur = s3_ff;
         fpr_pkg::STG_FOUR:  stage_cur = s4_ff;
         default:            stage_cur = s1_ff;
      endcase
      stage_new = fpr_pkg::sat_stage(fpr_pkg::wide_type'(stage_cur)
                                     + fpr_pkg::wide_type'(prod >>> fpr_pkg::COEF_BITS));
   end

   // Output mode selection; a zero input passes straight through.
   always_comb begin
      case (mode_ff)
         fpr_pkg::MODE_LOWPASS:  y_raw = fpr_pkg::diff_type'(s4_ff);
         fpr_pkg::MODE_HIGHPASS: y_raw = fpr_pkg::diff_type'(x_ff) - fpr_pkg::diff_type'(s4_ff);
         fpr_pkg::MODE_BANDPASS: y_raw = fpr_pkg::diff_type'(s1_ff) - fpr_pkg::diff_type'(s4_ff);
         default:                y_raw = '0;
      endcase
      sample_out_in = (x_ff == '0) ? '0 : fpr_pkg::sat_sample(y_raw);
   end

   // Response valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state: configuration, response flag and filter stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= fpr_pkg::MODE_LOWPASS;
         fb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
         s4_ff        <= '0;
      end else begin
         if (csr_ch.valid && (csr_ch.addr == fpr_pkg::CSR_FILTER_MODE)) begin
            mode_ff <= fpr_pkg::mode_type'(csr_ch.wdata[1:0]);
         end
         if (csr_ch.valid && (csr_ch.addr == fpr_pkg::CSR_FEEDBACK_GAIN)) begin
            fb_ff <= csr_ch.wdata[fpr_pkg::FB_BITS-1:0];
         end
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.upd_en) begin
            case (ctl.upd_sel)
               fpr_pkg::STG_ONE:   s1_ff <= stage_new;
               fpr_pkg::STG_TWO:   s2_ff <= stage_new;
               fpr_pkg::STG_THREE: s3_ff <= stage_new;
               fpr_pkg::STG_FOUR:  s4_ff <= stage_new;
               default:            s1_ff <= s1_ff;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_ch.sample_in;
         c_ff <= req_ch.cutoff_coef;
      end
      if (ctl.err_en) begin
         e_ff <= e_in;
      end
      if (ctl.out_load) begin
         sample_out_ff <= sample_out_in;
      end
   end

   `FPR_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ch.ready)
   `FPR_ASSERT_IMP(a_load_when_free, clock, reset, ctl.out_load, !rsp_valid_ff || rsp_ch.ready)
   `FPR_ASSERT_IMP(a_zero_keeps_stages, clock, reset, ctl.upd_en || ctl.err_en, x_ff != '0)

endmodule

`default_nettype wire

// ===== sv/fpr_mul.sv =====
// Shared signed multiplier with a registered product, used for the
// feedback term and all four stage updates. Depends on fpr_pkg.
`default_nettype none

module fpr_mul (
   input  wire               clock,
   input  wire               en,
   input  fpr_pkg::mul_a_type a,
   input  fpr_pkg::diff_type  b,
   output fpr_pkg::prod_type  prod
);

   fpr_pkg::prod_type prod_ff;
   fpr_pkg::prod_type prod_in;

   // Both operands are signed; the product fits the full width.
   always_comb begin
      prod_in = fpr_pkg::prod_type'(a) * fpr_pkg::prod_type'(b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== sv/fpr_ctrl.sv =====
// Sequencer of the four-pole resonant filter: steps the shared multiplier
// through one sample. Depends on fpr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fpr_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  fpr_pkg::sts_type  sts,
   output fpr_pkg::ctl_type  ctl
);

   fpr_pkg::state_type state_ff;
   fpr_pkg::state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpr_pkg::ST_IDLE: begin
            if (sts.accept) begin
               state_in = sts.zero_in ? fpr_pkg::ST_OUT : fpr_pkg::ST_MUL_FB;
            end
         end
         fpr_pkg::ST_MUL_FB: state_in = fpr_pkg::ST_ERR;
         fpr_pkg::ST_ERR:    state_in = fpr_pkg::ST_MUL_S1;
         fpr_pkg::ST_MUL_S1: state_in = fpr_pkg::ST_UPD_S1;
         fpr_pkg::ST_UPD_S1: state_in = fpr_pkg::ST_MUL_S2;
         fpr_pkg::ST_MUL_S2: state_in = fpr_pkg::ST_UPD_S2;
         fpr_pkg::ST_UPD_S2: state_in = fpr_pkg::ST_MUL_S3;
         fpr_pkg::ST_MUL_S3: state_in = fpr_pkg::ST_UPD_S3;
         fpr_pkg::ST_UPD_S3: state_in = fpr_pkg::ST_MUL_S4;
         fpr_pkg::ST_MUL_S4: state_in = fpr_pkg::ST_UPD_S4;
         fpr_pkg::ST_UPD_S4: state_in = fpr_pkg::ST_OUT;
         fpr_pkg::ST_OUT: begin
            if (sts.out_free) begin
               state_in = fpr_pkg::ST_IDLE;
            end
         end
         default: state_in = fpr_pkg::ST_IDLE;
      endcase
   end

   // Outputs per state.
   always_comb begin
      ctl          = '0;
      ctl.b_sel    = fpr_pkg::BSEL_S1_S2;
      ctl.upd_sel  = fpr_pkg::STG_ONE;
      case (state_ff)
         fpr_pkg::ST_IDLE: ctl.ready = 1'b1;
         fpr_pkg::ST_MUL_FB: begin
            ctl.mul_en  = 1'b1;
            ctl.a_is_fb = 1'b1;
            ctl.b_sel   = fpr_pkg::BSEL_S1_S2;
         end
         fpr_pkg::ST_ERR: ctl.err_en = 1'b1;
         fpr_pkg::ST_MUL_S1: begin
            ctl.mul_en = 1'b1;
            ctl.b_sel  = fpr_pkg::BSEL_ERR;
         end
         fpr_pkg::ST_UPD_S1: begin
            ctl.upd_en  = 1'b1;
            ctl.upd_sel = fpr_pkg::STG_ONE;
         end
         fpr_pkg::ST_MUL_S2: begin
            ctl.mul_en = 1'b1;
            ctl.b_sel  = fpr_pkg::BSEL_S1_S2;
         end
         fpr_pkg::ST_UPD_S2: begin
            ctl.upd_en  = 1'b1;
            ctl.upd_sel = fpr_pkg::STG_TWO;
         end
         fpr_pkg::ST_MUL_S3: begin
            ctl.mul_en = 1'b1;
            ctl.b_sel  = fpr_pkg::BSEL_S2_S3;
         end
         fpr_pkg::ST_UPD_S3: begin
            ctl.upd_en  = 1'b1;
            ctl.upd_sel = fpr_pkg::STG_THREE;
         end
         fpr_pkg::ST_MUL_S4: begin
            ctl.mul_en = 1'b1;
            ctl.b_sel  = fpr_pkg::BSEL_S3_S4;
         end
         fpr_pkg::ST_UPD_S4: begin
            ctl.upd_en  = 1'b1;
            ctl.upd_sel = fpr_pkg::STG_FOUR;
         end
         fpr_pkg::ST_OUT: ctl.out_load = sts.out_free;
         default: ctl.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // At most one datapath action per cycle, and a new word leaves idle.
   `FPR_ASSERT_ALWAYS(a_one_action, clock, reset, $onehot0({ctl.mul_en, ctl.err_en, ctl.upd_en, ctl.out_load}))
   `FPR_ASSERT_NEXT(a_leave_idle, clock, reset, sts.accept && ctl.ready, state_ff != fpr_pkg::ST_IDLE)

endmodule

`default_nettype wire

// ===== tb/sv/fpr_response_checker.sv =====
// Response checker for the four-pole resonant filter: it watches the three
// channels, predicts each filtered sample and compares it with the response.
// Depends on fpr_pkg and the channel interfaces in fpr_ifs.
`timescale 1ns / 100ps

module fpr_response_checker (
   input  wire  clock,
   input  wire  reset,
   fpr_req_if   req_mon,
   fpr_rsp_if   rsp_mon,
   fpr_csr_if   csr_mon,
   output int   mismatch_count,
   output int   pending_count
);

   localparam longint STAGE_HI  = 64'sd2147483647;
   localparam longint STAGE_LO  = -STAGE_HI - 64'sd1;
   localparam longint SAMPLE_HI = (64'sd1 <<< (fpr_pkg::SAMPLE_BITS - 1)) - 64'sd1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 64'sd1;

   // Shadow copy of the filter registers and its four poles.
   fpr_pkg::mode_type   mode_reg;
   fpr_pkg::fb_type     gain_reg;
   fpr_pkg::stage_type  pole [4];
   int                  errors_seen;

   // Samples still owed by the filter, oldest first.
   fpr_pkg::sample_type expected_samples [$];

   function automatic longint saturate(input longint v, input longint lo, input longint hi);
      if (v < lo) begin
         return lo;
      end else if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   // One pole moves toward its target by c times the difference, floored.
   function automatic fpr_pkg::stage_type pole_update(input fpr_pkg::stage_type s,
                                                      input longint c, input longint d);
      longint delta;
      delta = (c * d) >>> fpr_pkg::COEF_BITS;
      return fpr_pkg::stage_type'(saturate(longint'(s) + delta, STAGE_LO, STAGE_HI));
   endfunction

   // Advance the poles by one sample and give the filtered output.
   task automatic filter_step(input fpr_pkg::sample_type x_in, input fpr_pkg::coef_type c_in,
                              output fpr_pkg::sample_type y_out);
      longint x;
      longint c;
      longint fb_term;
      longint err;
      longint y;
      x = longint'(x_in);
      c = longint'(c_in);
      if (x == 0) begin
         // A zero sample passes straight through and leaves the poles alone.
         y_out = '0;
      end else begin
         fb_term = (longint'(gain_reg) * (longint'(pole[0]) - longint'(pole[1])))
                   >>> fpr_pkg::FB_FRAC;
         err = saturate(x - longint'(pole[0]) + fb_term, STAGE_LO, STAGE_HI);
         pole[0] = pole_update(pole[0], c, err);
         pole[1] = pole_update(pole[1], c, longint'(pole[0]) - longint'(pole[1]));
         pole[2] = pole_update(pole[2], c, longint'(pole[1]) - longint'(pole[2]));
         pole[3] = pole_update(pole[3], c, longint'(pole[2]) - longint'(pole[3]));
         case (mode_reg)
            fpr_pkg::MODE_LOWPASS:  y = longint'(pole[3]);
            fpr_pkg::MODE_HIGHPASS: y = x - longint'(pole[3]);
            fpr_pkg::MODE_BANDPASS: y = longint'(pole[0]) - longint'(pole[3]);
            default:                y = 0;
         endcase
         y_out = fpr_pkg::sample_type'(saturate(y, SAMPLE_LO, SAMPLE_HI));
      end
   endtask

   // Everything is sampled at the rising edge, before the edge's updates land.
   always @(posedge clock) begin : monitor
      fpr_pkg::sample_type predicted;
      fpr_pkg::sample_type oldest;
      if (reset) begin
         mode_reg = fpr_pkg::MODE_LOWPASS;
         gain_reg = '0;
         for (int i = 0; i < 4; i++) begin
            pole[i] = '0;
         end
         expected_samples.delete();
         errors_seen = 0;
      end else begin
         // Register writes; indexes outside the map are dropped.
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.addr == fpr_pkg::CSR_FILTER_MODE) begin
               mode_reg = fpr_pkg::mode_type'(csr_mon.wdata[1:0]);
            end else if (csr_mon.addr == fpr_pkg::CSR_FEEDBACK_GAIN) begin
               gain_reg = fpr_pkg::fb_type'(csr_mon.wdata);
            end
         end

         // Responses are checked before this edge's request is queued, so a
         // response that arrives with nothing owed is always caught.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected response word, sample_out %0d with nothing owed",
                        $time, rsp_mon.sample_out);
               errors_seen++;
            end else begin
               oldest = expected_samples.pop_front();
               if (rsp_mon.sample_out !== oldest) begin
                  $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                           $time, oldest, rsp_mon.sample_out);
                  errors_seen++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            filter_step(req_mon.sample_in, req_mon.cutoff_coef, predicted);
            expected_samples.push_back(predicted);
         end
      end
      mismatch_count <= errors_seen;
      pending_count  <= expected_samples.size();
   end

endmodule

// ===== tb/sv/four_pole_resonant_filter_test.sv =====
// Top of the four-pole resonant filter testbench: clock, reset, stimulus on
// the request and register channels, response back-pressure and the verdict.
// Depends on fpr_pkg, fpr_ifs, the filter RTL and fpr_response_checker.
`timescale 1ns / 100ps

module four_pole_resonant_filter_test;

   localparam int         STALL_LIMIT   = 2000;
   localparam int         SETTLE_CYCLES = 4;
   localparam int         PHASE_WORDS   = 250;
   localparam int         RANDOM_PHASES = 8;
   localparam fpr_pkg::csr_addr_type CSR_SPARE_LO = fpr_pkg::csr_addr_type'(2);
   localparam fpr_pkg::csr_addr_type CSR_SPARE_HI = fpr_pkg::csr_addr_type'(3);
   localparam fpr_pkg::sample_type SAMPLE_HI = {1'b0, {(fpr_pkg::SAMPLE_BITS-1){1'b1}}};
   localparam fpr_pkg::sample_type SAMPLE_LO = {1'b1, {(fpr_pkg::SAMPLE_BITS-1){1'b0}}};
   localparam fpr_pkg::coef_type   COEF_HI   = '1;
   localparam fpr_pkg::fb_type     GAIN_HI   = '1;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   idle_cycles = 0;
   int   stall_left = 0;
   logic quiet_run = 1'b0;

   fpr_req_if req_bus ();
   fpr_rsp_if rsp_bus ();
   fpr_csr_if csr_bus ();

   four_pole_resonant_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   fpr_response_checker response_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response back-pressure: random idle cycles, now and then a long stall,
   // and none in the quiet phase once any stall already under way ends.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (quiet_run) begin
         rsp_bus.ready <= 1'b1;
      end else if ($urandom_range(999) < 2) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= $urandom_range(40, 10);
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= 35);
      end
   end

   // Watchdog: too long without any word moving on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Offer one request word after a random number of idle cycles and hold it
   // until the filter takes it.
   task automatic send_word(input fpr_pkg::sample_type s, input fpr_pkg::coef_type c);
      while (!quiet_run && $urandom_range(99) < 35) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.sample_in   <= s;
      req_bus.cutoff_coef <= c;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(input fpr_pkg::csr_addr_type a, input fpr_pkg::csr_data_type d);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= a;
      csr_bus.wdata <= d;
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every response is back and the sequencer has come to rest.
   task automatic wait_drained;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Set both registers. Junk goes to a spare index first and the mode word
   // carries random upper bits; neither may have any effect.
   task automatic configure(input fpr_pkg::mode_type m, input fpr_pkg::fb_type g);
      fpr_pkg::csr_data_type mode_word;
      mode_word = fpr_pkg::csr_data_type'($urandom);
      mode_word[1:0] = m;
      csr_write(fpr_pkg::csr_addr_type'($urandom_range(CSR_SPARE_HI, CSR_SPARE_LO)),
                fpr_pkg::csr_data_type'($urandom));
      csr_write(fpr_pkg::CSR_FILTER_MODE, mode_word);
      csr_write(fpr_pkg::CSR_FEEDBACK_GAIN, fpr_pkg::csr_data_type'(g));
   endtask

   // Mostly full-range audio, with zeros, extremes and quiet signals mixed in.
   function automatic fpr_pkg::sample_type rand_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) begin
         return '0;
      end else if (pick < 10) begin
         case ($urandom_range(3))
            0:       return SAMPLE_HI;
            1:       return SAMPLE_LO;
            2:       return fpr_pkg::sample_type'(1);
            default: return fpr_pkg::sample_type'(-1);
         endcase
      end else if (pick < 25) begin
         return fpr_pkg::sample_type'(int'($urandom_range(8191)) - 4096);
      end
      return fpr_pkg::sample_type'($urandom);
   endfunction

   function automatic fpr_pkg::coef_type rand_coef();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) begin
         return '0;
      end else if (pick < 10) begin
         return COEF_HI;
      end else if (pick < 30) begin
         return fpr_pkg::coef_type'($urandom_range(1023, 1));
      end
      return fpr_pkg::coef_type'($urandom);
   endfunction

   initial begin : stimulus
      fpr_pkg::mode_type m;
      fpr_pkg::fb_type   g;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.sample_in   <= '0;
      req_bus.cutoff_coef <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.addr        <= '0;
      csr_bus.wdata       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes and zero input per mode, a zero coefficient in
      // lowpass and highpass, and no, the largest and in-between feedback.
      configure(fpr_pkg::MODE_LOWPASS, '0);
      send_word(SAMPLE_HI, COEF_HI);
      send_word(SAMPLE_HI, COEF_HI);
      send_word(SAMPLE_LO, COEF_HI);
      send_word('0, COEF_HI);
      send_word(fpr_pkg::sample_type'(1), '0);
      send_word(fpr_pkg::sample_type'(-1), fpr_pkg::coef_type'(1));
      wait_drained();

      configure(fpr_pkg::MODE_HIGHPASS, GAIN_HI);
      send_word(SAMPLE_LO, COEF_HI);
      send_word(SAMPLE_HI, fpr_pkg::coef_type'(16'h8000));
      send_word('0, '0);
      send_word(SAMPLE_HI, COEF_HI);
      send_word(fpr_pkg::sample_type'(-1), COEF_HI);
      wait_drained();

      configure(fpr_pkg::MODE_BANDPASS, fpr_pkg::fb_type'(20'h10000));
      send_word(SAMPLE_HI, fpr_pkg::coef_type'(16'h4000));
      send_word(SAMPLE_LO, fpr_pkg::coef_type'(16'h4000));
      send_word('0, COEF_HI);
      send_word(fpr_pkg::sample_type'(100), COEF_HI);
      send_word(fpr_pkg::sample_type'(-100), fpr_pkg::coef_type'(1));
      wait_drained();

      // Unused mode still moves the poles.
      configure(fpr_pkg::MODE_ZERO, fpr_pkg::fb_type'(20'h3FFFF));
      send_word(SAMPLE_HI, COEF_HI);
      send_word(SAMPLE_LO, fpr_pkg::coef_type'(16'h1234));
      send_word('0, COEF_HI);
      send_word(fpr_pkg::sample_type'(-5000), fpr_pkg::coef_type'(16'hFFF0));
      wait_drained();

      // Random phases: every mode, feedback from none to the largest, and
      // one phase with no idling on either side.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         m = (p < 4) ? fpr_pkg::mode_type'(p) : fpr_pkg::mode_type'($urandom_range(3));
         case (p % 4)
            0:       g = '0;
            1:       g = GAIN_HI;
            2:       g = fpr_pkg::fb_type'($urandom);
            default: g = fpr_pkg::fb_type'($urandom_range(262143));
         endcase
         configure(m, g);
         quiet_run <= (p == 5);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            send_word(rand_sample(), rand_coef());
         end
         wait_drained();
      end

      quiet_run <= 1'b0;
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
